### sv/atfe_pkg.sv
package atfe_pkg;

    localparam int POS_W      = 14;
    localparam int MUL_W      = 8;
    localparam int PROD_W     = POS_W + MUL_W;
    localparam int TENTHS_W   = 12;
    localparam int BCD_W      = 16;
    localparam int DD_STEPS   = TENTHS_W;
    localparam int FRAME_LEN  = 10;
    localparam int CNT_W      = 4;

    localparam logic [MUL_W-1:0]  TENTHS_MUL = 8'd225;
    localparam logic [PROD_W-1:0] TENTHS_RND = 22'd512;
    localparam int                TENTHS_SHIFT = 10;

    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [3:0] CH_DIGIT = 4'h3;

    localparam logic [CNT_W-1:0] CNT_LAST = 4'(FRAME_LEN - 1);

    // Data handed from one conversion cell to the next.
    typedef struct packed {
        logic [BCD_W-1:0]    bcd;
        logic [TENTHS_W-1:0] bin;
        logic [3:0]          stat;
    } t_cell;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = 8'h30 + {4'd0, v};
        end else begin
            c = 8'h41 + {4'd0, v} - 8'd10;
        end
        return c;
    endfunction

endpackage

### sv/angle_telemetry_frame_encoder.sv
// Angle telemetry frame encoder.
// The slave channel takes one sensor sample per word: tdata bits 15..0 hold the
// raw angle word (bits 14..1 are the position) and bits 19..16 the status nibble.
// The master channel sends the ten-byte ASCII frame "[X" + four angle digits +
// status hex + two checksum hex + "]", one byte per word, with tlast on "]".
// An accepted sample passes a scaling register, a row of twelve
// binary-to-decimal cells and the output register before its first byte is offered.
// Throughput is one frame byte per cycle while tready stays high; the byte-wide
// output shift register sets the sample rate. While a frame is going out,
// the next samples move through the cell row; the first of them to reach its end
// waits there, and from then on the whole row and the input hold until the
// output register takes that sample.
// When the receiver drops tready, the current byte holds, the cell row stops
// once a finished frame waits at its end, and then tready on the input falls.
// Synchronous active-low reset empties the cell row and the output register;
// no partial frame survives it.
module angle_telemetry_frame_encoder
    import atfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // raw_angle_word[15:0], status_nibble[19:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // frame_byte[7:0]
    output logic        o_m_axis_tlast
);

    logic  adv;
    logic  load;
    logic  c_valid [DD_STEPS+1];
    t_cell c_data  [DD_STEPS+1];

    // The whole row moves together unless a finished frame is stuck at its end.
    assign adv             = !c_valid[DD_STEPS] || load;
    assign o_s_axis_tready = adv;

    atfe_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_s_axis_tvalid),
        .i_word  (i_s_axis_tdata[15:0]),
        .i_stat  (i_s_axis_tdata[19:16]),
        .o_valid (c_valid[0]),
        .o_data  (c_data[0])
    );

    for (genvar g = 0; g < DD_STEPS; g++) begin : g_cell
        atfe_dd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (c_valid[g]),
            .i_data  (c_data[g]),
            .o_valid (c_valid[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    atfe_serializer u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid[DD_STEPS]),
        .i_data   (c_data[DD_STEPS]),
        .o_load   (load),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

    a_last_is_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata == CH_RBR)
        else $error("frame end flag on a byte other than the closing bracket");

    a_frame_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast
        |=> !o_m_axis_tvalid || o_m_axis_tdata == CH_LBR)
        else $error("next frame does not open with a bracket");

    a_idle_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while the output register is empty");

endmodule

### sv/atfe_scale.sv
module atfe_scale
    import atfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  logic [15:0] i_word,
    input  logic [3:0]  i_stat,
    output logic        o_valid,
    output t_cell       o_data
);

    logic [POS_W-1:0]  pos;
    logic [PROD_W-1:0] prod;
    logic              r_valid;
    t_cell             r_data;
    t_cell             n_data;

    assign pos  = i_word[POS_W:1];
    assign prod = {{MUL_W{1'b0}}, pos} * {{POS_W{1'b0}}, TENTHS_MUL} + TENTHS_RND;

    always_comb begin
        n_data      = '0;
        n_data.bin  = prod[TENTHS_SHIFT +: TENTHS_W];
        n_data.stat = i_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/atfe_dd_cell.sv
module atfe_dd_cell
    import atfe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_cell i_data,
    output logic  o_valid,
    output t_cell o_data
);

    logic [BCD_W-1:0] adj;
    logic             r_valid;
    t_cell            r_data;
    t_cell            n_data;

    // One double-dabble step: correct each decimal digit, then shift in the next bit.
    always_comb begin
        for (int d = 0; d < BCD_W / 4; d++) begin
            if (i_data.bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = i_data.bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = i_data.bcd[4*d +: 4];
            end
        end
        n_data.bcd  = {adj[BCD_W-2:0], i_data.bin[TENTHS_W-1]};
        n_data.bin  = {i_data.bin[TENTHS_W-2:0], 1'b0};
        n_data.stat = i_data.stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/atfe_serializer.sv
module atfe_serializer
    import atfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell      i_data,
    output logic       o_load,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    logic [7:0]       r_frame [FRAME_LEN];
    logic [7:0]       n_frame [FRAME_LEN];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_valid;
    logic             n_valid;
    logic             fire;
    logic             last;
    logic [7:0]       dig [4];
    logic [7:0]       st_ch;
    logic [7:0]       sum;

    assign last   = (r_cnt == CNT_LAST);
    assign fire   = r_valid && i_tready;
    assign o_load = i_valid && (!r_valid || (fire && last));

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dig[k] = {CH_DIGIT, i_data.bcd[BCD_W-4-4*k +: 4]};
        end
        st_ch = hex_char(i_data.stat);
        sum   = CH_X ^ dig[0] ^ dig[1] ^ dig[2] ^ dig[3] ^ st_ch;
    end

    always_comb begin
        n_frame = r_frame;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        if (o_load) begin
            n_frame[0] = CH_LBR;
            n_frame[1] = CH_X;
            n_frame[2] = dig[0];
            n_frame[3] = dig[1];
            n_frame[4] = dig[2];
            n_frame[5] = dig[3];
            n_frame[6] = st_ch;
            n_frame[7] = hex_char(sum[7:4]);
            n_frame[8] = hex_char(sum[3:0]);
            n_frame[9] = CH_RBR;
            n_cnt      = '0;
            n_valid    = 1'b1;
        end else if (fire) begin
            // The word on the port is always the head of the shift line.
            for (int k = 0; k < FRAME_LEN - 1; k++) begin
                n_frame[k] = r_frame[k+1];
            end
            n_cnt   = r_cnt + 4'd1;
            n_valid = !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
        r_frame <= n_frame;
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_frame[0];
    assign o_tlast  = last;

endmodule
